>>> rtl/c8fp_pkg.sv
// Shared constants, result type and CRC-8 byte update for the checked frame parser.
package c8fp_pkg;

    localparam logic [7:0] HDR0     = 8'h55;
    localparam logic [7:0] HDR1     = 8'hAA;
    localparam logic [7:0] TRL0     = 8'h0D;
    localparam logic [7:0] TRL1     = 8'h0A;
    localparam logic [7:0] CRC_POLY = 8'h8C;
    localparam logic [3:0] LEN_MIN  = 4'd7;
    localparam logic [3:0] LEN_MAX  = 4'd10;
    localparam int         KEEP_BYTES = 7;

    localparam logic [2:0] PH_LEN  = 3'd0;
    localparam logic [2:0] PH_DATA = 3'd1;
    localparam logic [2:0] PH_CRC  = 3'd2;
    localparam logic [2:0] PH_TRL0 = 3'd3;
    localparam logic [2:0] PH_TRL1 = 3'd4;

    typedef struct packed {
        logic signed [15:0] x_speed;
        logic signed [15:0] y_speed;
        logic signed [15:0] w_speed;
        logic [7:0]         ctrl_flag;
    } c8fp_result_t;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] v;
        v = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
        end
        return v;
    endfunction

    localparam logic [7:0] HDR_CRC = crc8_update(crc8_update(8'h00, HDR0), HDR1);

endpackage

>>> rtl/c8fp_parser.sv
// Frame state machine: header hunt, length check, payload capture, CRC and trailer check.
module c8fp_parser
    import c8fp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  logic [7:0]   rx_byte,
    output logic         res_valid,
    output c8fp_result_t res
);

    logic       hunting_reg, hunting_next;
    logic [7:0] prev_reg, prev_next;
    logic [2:0] phase_reg, phase_next;
    logic [3:0] len_reg, len_next;
    logic [3:0] count_reg, count_next;
    logic [7:0] crc_reg, crc_next;
    logic [7:0] payload_reg [KEEP_BYTES];

    logic [7:0] crc_upd;
    logic [3:0] count_inc;
    logic       store_en;

    assign crc_upd   = crc8_update(crc_reg, rx_byte);
    assign count_inc = count_reg + 4'd1;
    assign store_en  = step && !hunting_reg && (phase_reg == PH_DATA)
                       && (count_reg < 4'(KEEP_BYTES));

    always_comb
    begin
        hunting_next = hunting_reg;
        prev_next    = prev_reg;
        phase_next   = phase_reg;
        len_next     = len_reg;
        count_next   = count_reg;
        crc_next     = crc_reg;
        res_valid    = 1'b0;
        if (step) begin
            if (hunting_reg) begin
                if (rx_byte == HDR1) begin
                    if (prev_reg == HDR0) begin
                        hunting_next = 1'b0;
                        phase_next   = PH_LEN;
                        count_next   = 4'd0;
                        len_next     = 4'd0;
                        crc_next     = HDR_CRC;
                    end
                end else begin
                    prev_next = rx_byte;
                end
            end else begin
                // Any failure, and the end of every frame, drops back to the hunt with the frame state cleared.
                hunting_next = 1'b1;
                prev_next    = 8'h00;
                phase_next   = PH_LEN;
                len_next     = 4'd0;
                count_next   = 4'd0;
                crc_next     = 8'h00;
                unique case (phase_reg)
                    PH_LEN:
                    begin
                        if (rx_byte >= 8'(LEN_MIN) && rx_byte <= 8'(LEN_MAX)) begin
                            hunting_next = 1'b0;
                            prev_next    = prev_reg;
                            len_next     = rx_byte[3:0];
                            crc_next     = crc_upd;
                            phase_next   = PH_DATA;
                        end
                    end
                    PH_DATA:
                    begin
                        hunting_next = 1'b0;
                        prev_next    = prev_reg;
                        len_next     = len_reg;
                        crc_next     = crc_upd;
                        if (count_inc >= len_reg) begin
                            count_next = 4'd0;
                            phase_next = PH_CRC;
                        end else begin
                            count_next = count_inc;
                            phase_next = PH_DATA;
                        end
                    end
                    PH_CRC:
                    begin
                        if (rx_byte == crc_reg) begin
                            hunting_next = 1'b0;
                            prev_next    = prev_reg;
                            len_next     = len_reg;
                            crc_next     = crc_reg;
                            phase_next   = PH_TRL0;
                        end
                    end
                    PH_TRL0:
                    begin
                        if (rx_byte == TRL0) begin
                            hunting_next = 1'b0;
                            prev_next    = prev_reg;
                            len_next     = len_reg;
                            crc_next     = crc_reg;
                            phase_next   = PH_TRL1;
                        end
                    end
                    PH_TRL1:
                    begin
                        res_valid = (rx_byte == TRL1);
                    end
                    default:
                    begin
                        res_valid = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            hunting_reg <= 1'b1;
            prev_reg    <= 8'h00;
            phase_reg   <= PH_LEN;
            len_reg     <= 4'd0;
            count_reg   <= 4'd0;
            crc_reg     <= 8'h00;
        end else begin
            hunting_reg <= hunting_next;
            prev_reg    <= prev_next;
            phase_reg   <= phase_next;
            len_reg     <= len_next;
            count_reg   <= count_next;
            crc_reg     <= crc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_en) begin
            payload_reg[count_reg[2:0]] <= rx_byte;
        end
    end

    assign res.x_speed   = signed'({payload_reg[1], payload_reg[0]});
    assign res.y_speed   = signed'({payload_reg[3], payload_reg[2]});
    assign res.w_speed   = signed'({payload_reg[5], payload_reg[4]});
    assign res.ctrl_flag = payload_reg[6];

    a_result_only_on_trailer: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (!hunting_reg && phase_reg == PH_TRL1 && step))
        else $error("Result raised outside the second trailer byte.");

    a_result_returns_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> (hunting_reg && prev_reg == 8'h00 && crc_reg == 8'h00))
        else $error("Parser did not return to the hunt after a good frame.");

    a_phase_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        !hunting_reg |-> (phase_reg <= PH_TRL1 && count_reg < LEN_MAX))
        else $error("Frame phase or payload count out of range.");

    a_length_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!hunting_reg && phase_reg == PH_DATA) |-> (len_reg >= LEN_MIN && len_reg <= LEN_MAX))
        else $error("Payload phase entered with an invalid length.");

endmodule

>>> rtl/crc8_checked_frame_parser.sv
// Top level of the CRC-8 checked frame parser with its registered result port.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+------------------------------------------
//   input   | in_valid / in_stall  | rx_byte
//   output  | out_valid / out_stall| x_speed, y_speed, w_speed, ctrl_flag
//
// A byte can be taken on every clock while the input is not stalled.
// A result appears in the output register in the cycle after the closing 0x0A.
// The output register is the only buffer: while it holds a result that is
// stalled, the input is stalled as well.
// Reset clears the frame state and returns the parser to the header hunt.
module crc8_checked_frame_parser
    import c8fp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] x_speed,
    output logic signed [15:0] y_speed,
    output logic signed [15:0] w_speed,
    output logic [7:0]         ctrl_flag
);

    logic         in_accept;
    logic         res_valid;
    c8fp_result_t res;
    logic         out_valid_reg, out_valid_next;
    c8fp_result_t out_reg;

    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    c8fp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (in_accept),
        .rx_byte   (rx_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb
    begin
        if (in_stall) begin
            out_valid_next = out_valid_reg;
        end else begin
            out_valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid) begin
            out_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign x_speed   = out_reg.x_speed;
    assign y_speed   = out_reg.y_speed;
    assign w_speed   = out_reg.w_speed;
    assign ctrl_flag = out_reg.ctrl_flag;

endmodule
